/* design/pfs_pkg.sv */
// Shared types, constants and state encoding for the PLL factor search.
package pfs_pkg;

   // Field widths
   localparam int TGT_W   = 32;          // target in Hz
   localparam int SRC_W   = 20;          // source in kHz
   localparam int K_W     = 3;
   localparam int M_W     = 5;
   localparam int N_W     = 6;
   localparam int DIFF_W  = 32;
   localparam int TKHZ_W  = 23;          // (2^32-1)/1000 fits in 23 bits
   localparam int SUM_W   = SRC_W + 2;   // source * k, k up to 4
   localparam int PROD_W  = SRC_W + 7;   // source * n * k, n up to 32
   localparam int REM_W   = 4;           // remainder of a divide by m (m up to 16)

   // Target scaling: floor(hz / 1000) = (hz * ceil(2^38 / 1000)) >> 38 for any 32-bit hz
   localparam int RECIP_W   = 29;
   localparam int SCALE_W   = TGT_W + RECIP_W;
   localparam int KHZ_SHIFT = 38;
   localparam logic [RECIP_W-1:0] KHZ_RECIP = 29'd274877907;

   // Shared divider geometry: (source * k) / m
   localparam int DIV_W   = SUM_W;
   localparam int DVSR_W  = M_W;
   localparam int CNT_W   = 5;

   // Limits and reset values
   localparam logic [K_W-1:0] K_MAX   = 3'd4;
   localparam logic [M_W-1:0] M_MAX   = 5'd16;
   localparam logic [N_W-1:0] N_MAX   = 6'd32;
   localparam logic [K_W-1:0] K_RESET = 3'd4;
   localparam logic [M_W-1:0] M_RESET = 5'd16;
   localparam logic [N_W-1:0] N_RESET = 6'd16;

   localparam logic [DIFF_W-1:0] NONE_DIFF  = 32'hffff_ffff;
   localparam logic [9:0]        HZ_PER_KHZ = 10'd1000;

   // Register file
   localparam int CSR_W     = 6;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_K_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_M_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_N_LIMIT = 2'd2;

   typedef struct packed {
      logic [TGT_W-1:0] target_hz;
      logic [SRC_W-1:0] source_khz;
   } pfs_req_type;

   typedef struct packed {
      logic [N_W-1:0]    best_n;
      logic [K_W-1:0]    best_k;
      logic [M_W-1:0]    best_m;
      logic [DIFF_W-1:0] shortfall_khz;
      logic              found;
   } pfs_rsp_type;

   typedef struct packed {
      logic [K_W-1:0] k_limit;
      logic [M_W-1:0] m_limit;
      logic [N_W-1:0] n_limit;
   } pfs_limits_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVSR_W-1:0] divisor;
   } pfs_div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
      logic [DVSR_W-1:0] remainder;
   } pfs_div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_K_STEP,
      ST_M_STEP,
      ST_MDIV_GO,
      ST_MDIV_WAIT,
      ST_N_STEP,
      ST_DONE
   } pfs_state_type;

endpackage

/* design/pfs_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
module pfs_divider import pfs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  pfs_div_req_type div_req,
   output pfs_div_rsp_type div_rsp
);

   logic              active_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DVSR_W-1:0] rem_ff;
   logic [DVSR_W-1:0] divisor_ff;
   logic [DIV_W-1:0]  quo_ff;

   logic [DVSR_W:0]   trial;
   logic              ge;
   logic [DVSR_W:0]   diff;

   // Trial subtract of the shifted partial remainder
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      ge    = trial >= {1'b0, divisor_ff};
      diff  = trial - {1'b0, divisor_ff};
   end

   // Control: active flag, step count, done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            active_ff <= 1'b1;
            cnt_ff    <= '0;
         end else if (active_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   // Datapath: dividend shifts out at the top, quotient bits shift in at the bottom
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff     <= '0;
         quo_ff     <= div_req.dividend;
         divisor_ff <= div_req.divisor;
      end else if (active_ff) begin
         rem_ff <= ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

/* design/pfs_search.sv */
// Search sequencer: walks k, m and n and keeps the closest setting at or below target.
module pfs_search import pfs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  pfs_req_type     req_data,
   input  pfs_limits_type  limits,
   input  pfs_div_rsp_type div_rsp,
   output pfs_div_req_type div_req,
   output logic            busy,
   output logic            rsp_valid,
   output pfs_rsp_type     rsp_data
);

   pfs_state_type state_ff, state_in;

   logic [TGT_W-1:0]  tgt_hz_ff;
   logic [SRC_W-1:0]  src_ff;
   logic [K_W-1:0]    kl_ff;
   logic [M_W-1:0]    ml_ff;
   logic [N_W-1:0]    nl_ff;
   logic [TKHZ_W-1:0] target_ff;

   logic [K_W-1:0]    k_ff;
   logic [M_W-1:0]    m_ff;
   logic [N_W-1:0]    n_ff;
   logic [SUM_W-1:0]  s_ff;     // source * k
   logic [SUM_W-1:0]  qs_ff;    // (source * k) / m
   logic [REM_W-1:0]  rs_ff;    // (source * k) % m
   logic [PROD_W-1:0] q_ff;     // running floor(source * n * k / m)
   logic [REM_W-1:0]  r_ff;     // running remainder

   logic [K_W-1:0]    bk_ff;
   logic [M_W-1:0]    bm_ff;
   logic [N_W-1:0]    bn_ff;
   logic [DIFF_W-1:0] bd_ff;

   logic              go;
   logic              limit_zero;
   logic [SCALE_W-1:0] scale_prod;
   logic [REM_W:0]    r_sum;
   logic              wrap;
   logic [REM_W:0]    r_wrapped;
   logic [REM_W-1:0]  r_next;
   logic [PROD_W-1:0] v_next;
   logic              fits;
   logic [TKHZ_W-1:0] diff;
   logic              better;
   logic              exact;
   logic [N_W-1:0]    n_next;
   logic              last_n;

   assign go         = start && (state_ff == ST_IDLE);
   assign limit_zero = (kl_ff == '0) || (ml_ff == '0) || (nl_ff == '0);

   // Target to kHz: reciprocal multiply, exact over the whole 32-bit range
   assign scale_prod = SCALE_W'(tgt_hz_ff) * SCALE_W'(KHZ_RECIP);

   // One n step: add the per-step quotient and remainder, fold the remainder once
   always_comb begin
      r_sum     = {1'b0, r_ff} + {1'b0, rs_ff};
      wrap      = r_sum >= m_ff;
      r_wrapped = r_sum - m_ff;
      r_next    = wrap ? r_wrapped[REM_W-1:0] : r_sum[REM_W-1:0];
      v_next    = q_ff + PROD_W'(qs_ff) + PROD_W'(wrap);
      fits      = v_next <= PROD_W'(target_ff);
      diff      = target_ff - v_next[TKHZ_W-1:0];
      better    = fits && (DIFF_W'(diff) < bd_ff);
      exact     = fits && (diff == '0);
      n_next    = n_ff + 1'b1;
      last_n    = n_next == nl_ff;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (start) state_in = ST_SCALE;
         ST_SCALE:     state_in = limit_zero ? ST_DONE : ST_K_STEP;
         ST_K_STEP:    state_in = ST_M_STEP;
         ST_M_STEP:    state_in = ST_MDIV_GO;
         ST_MDIV_GO:   state_in = ST_MDIV_WAIT;
         ST_MDIV_WAIT: if (div_rsp.done) state_in = ST_N_STEP;
         ST_N_STEP: begin
            if (exact) begin
               state_in = ST_DONE;
            end else if (last_n) begin
               if (m_ff != ml_ff)      state_in = ST_M_STEP;
               else if (k_ff != kl_ff) state_in = ST_K_STEP;
               else                    state_in = ST_DONE;
            end
         end
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = DIV_W'(s_ff);
      div_req.divisor  = DVSR_W'(m_ff);
      case (state_ff)
         ST_MDIV_GO: div_req.start = 1'b1;
         default:    div_req.start = 1'b0;
      endcase
      busy      = state_ff != ST_IDLE;
      rsp_valid = state_ff == ST_DONE;
   end

   always_comb begin
      rsp_data.best_n        = bn_ff;
      rsp_data.best_k        = bk_ff;
      rsp_data.best_m        = bm_ff;
      rsp_data.shortfall_khz = bd_ff;
      rsp_data.found         = bk_ff != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Loop counters, running quotient and best-so-far
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               tgt_hz_ff <= req_data.target_hz;
               src_ff    <= req_data.source_khz;
               kl_ff     <= (limits.k_limit > K_MAX) ? K_MAX : limits.k_limit;
               ml_ff     <= (limits.m_limit > M_MAX) ? M_MAX : limits.m_limit;
               nl_ff     <= (limits.n_limit > N_MAX) ? N_MAX : limits.n_limit;
               bk_ff     <= '0;
               bm_ff     <= '0;
               bn_ff     <= '0;
               bd_ff     <= NONE_DIFF;
               k_ff      <= '0;
               s_ff      <= '0;
            end
         end
         ST_SCALE: target_ff <= scale_prod[KHZ_SHIFT +: TKHZ_W];
         ST_K_STEP: begin
            k_ff <= k_ff + 1'b1;
            s_ff <= s_ff + SUM_W'(src_ff);
            m_ff <= '0;
         end
         ST_M_STEP: m_ff <= m_ff + 1'b1;
         ST_MDIV_WAIT: begin
            if (div_rsp.done) begin
               qs_ff <= div_rsp.quotient[SUM_W-1:0];
               rs_ff <= div_rsp.remainder[REM_W-1:0];
               q_ff  <= '0;
               r_ff  <= '0;
               n_ff  <= '0;
            end
         end
         ST_N_STEP: begin
            q_ff <= v_next;
            r_ff <= r_next;
            n_ff <= n_next;
            if (better) begin
               bd_ff <= DIFF_W'(diff);
               bk_ff <= k_ff;
               bm_ff <= m_ff;
               bn_ff <= n_next;
            end
         end
         default: ;
      endcase
   end

endmodule

/* design/pll_factor_search.sv */
// PLL factor search top level: limit registers, sequencer, shared divider.
//
// Give a target in Hz and a source in kHz on req_data and pulse start while
// busy is low. The block returns the n, k, m setting whose output
// floor(source * n * k / m) kHz comes closest to target/1000 without going
// over, trying k outermost, then m, then n, and stopping at an exact match.
// One result beat appears on rsp_data with rsp_valid high for exactly one
// cycle; the receiver cannot stall it, so it must take the beat then. The
// search time is set by the shared 22-step divider, used once for each
// (k, m) pair, and by the single n step per cycle, and an exact match ends
// it early; the target is turned into kHz by a reciprocal multiply registered
// in the scale state. The user must write limits through the csr_ port only
// while the block is idle; the block itself does not enforce it. A limit of
// zero gives the nothing-found result.
module pll_factor_search import pfs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pfs_req_type          req_data,
   output logic                 rsp_valid,
   output pfs_rsp_type          rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [K_W-1:0] k_limit_ff;
   logic [M_W-1:0] m_limit_ff;
   logic [N_W-1:0] n_limit_ff;

   pfs_limits_type  limits;
   pfs_div_req_type div_req;
   pfs_div_rsp_type div_rsp;

   // Limit registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         k_limit_ff <= K_RESET;
         m_limit_ff <= M_RESET;
         n_limit_ff <= N_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_K_LIMIT: k_limit_ff <= csr_wdata[K_W-1:0];
            CSR_M_LIMIT: m_limit_ff <= csr_wdata[M_W-1:0];
            CSR_N_LIMIT: n_limit_ff <= csr_wdata[N_W-1:0];
            default: ;
         endcase
      end
   end

   assign limits.k_limit = k_limit_ff;
   assign limits.m_limit = m_limit_ff;
   assign limits.n_limit = n_limit_ff;

   pfs_search u_search (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .limits    (limits),
      .div_rsp   (div_rsp),
      .div_req   (div_req),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   pfs_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // An accepted item keeps the block busy on the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after accepting an item");

   // One result beat per item, never two in a row
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A found result has a shortfall that fits in the TKHZ_W bits of the target in kHz
   a_found_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.shortfall_khz[DIFF_W-1:TKHZ_W] == '0)
      else $error("found result with out-of-range shortfall");

   // Nothing found means all factors zero and the full shortfall
   a_none_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.best_n == '0 && rsp_data.best_m == '0
         && rsp_data.shortfall_khz == NONE_DIFF)
      else $error("nothing-found result is inconsistent");

   // The divider start request is never asserted back to back
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> !div_req.start)
      else $error("divider started on back-to-back cycles");

endmodule
